[src/rcfd_pkg.sv]
`default_nettype none

package rcfd_pkg;

  // Sizing of the block.
  localparam int CHANNELS    = 16;
  localparam int FRAME_BYTES = 20;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 2);
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int HDR_BYTES   = 3;
  localparam int SCAN_MAX    = 16;
  localparam int SCAN_W      = $clog2(SCAN_MAX + 1);

  // Characters the decoder looks for.
  localparam logic [7:0] CHR_HASH  = 8'h23;
  localparam logic [7:0] CHR_H     = 8'h48;
  localparam logic [7:0] CHR_E     = 8'h45;
  localparam logic [7:0] CHR_X     = 8'h58;
  localparam logic [7:0] CHR_D     = 8'h44;
  localparam logic [7:0] CHR_G     = 8'h47;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_R     = 8'h52;
  localparam logic [7:0] CHR_V     = 8'h56;
  localparam logic [7:0] CHR_T     = 8'h54;
  localparam logic [7:0] CHR_8     = 8'h38;
  localparam logic [7:0] CHR_L     = 8'h4C;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_UA    = 8'h41;
  localparam logic [7:0] CHR_UF    = 8'h46;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_LF    = 8'h66;

  // Channel value constants.
  localparam logic signed [12:0] VAL_DEFAULT = 13'sd1500;
  localparam logic [13:0]        SRV_MAX     = 14'd3000;
  localparam logic signed [12:0] DEG_OFFSET  = 13'sd127;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_HEX  = 3'd1,
    KIND_DEG  = 3'd2,
    KIND_SRV  = 3'd3,
    KIND_SS8  = 3'd4,
    KIND_LED  = 3'd5
  } kind_t;

  // One classified frame, handed from the front to the back.
  typedef struct packed {
    kind_t kind;
    logic  ok;
  } job_t;

  // Read request into the frame store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

[src/rcfd_if.sv]
`default_nettype none

// Byte channel into the decoder.
interface rcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

// Channel result channel out of the decoder.
interface rcfd_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        frame_kind;
  logic              frame_ok;
  logic [3:0]        channel_index;
  logic signed [12:0] channel_value;
  logic              channel_present;
  logic              last_channel;

  modport source (output valid, output frame_kind, output frame_ok, output channel_index,
                  output channel_value, output channel_present, output last_channel,
                  input ready);
  modport sink   (input valid, input frame_kind, input frame_ok, input channel_index,
                  input channel_value, input channel_present, input last_channel,
                  output ready);
endinterface

`default_nettype wire

[src/rcfd_front.sv]
`default_nettype none

module rcfd_front
  import rcfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  rcfd_in_if.sink      in_ch,
  input  wire logic    queue_full,
  output logic         job_push,
  output job_t         job,
  input  wire rd_req_t rd_req,
  output logic [7:0]   rd_data,
  input  wire logic    store_release
);

  logic [CNT_W-1:0] count;
  logic             locked;
  logic [7:0]       head0;
  logic [7:0]       head1;
  logic [7:0]       head2;
  logic [7:0]       store [FRAME_BYTES];

  logic       accept;
  logic [7:0] head2_eff;
  logic       len_fixed;
  logic       len_min;
  logic       term_ok;
  logic       hdr_hex, hdr_deg, hdr_srv, hdr_ss8, hdr_led;

  // The store is held from the final word until the back has scanned it, or has taken its job if it needs no scan.
  assign in_ch.ready = !locked && !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign job_push    = accept && in_ch.end_of_frame;

  // A three-word frame ends on its third header position.
  assign head2_eff = (count == CNT_W'(2)) ? in_ch.data_byte : head2;
  assign len_fixed = (count == CNT_W'(FRAME_BYTES - 1));
  assign len_min   = (count >= CNT_W'(HDR_BYTES - 1));
  assign term_ok   = (in_ch.data_byte == CHR_HASH) && len_min;

  assign hdr_hex = (head0 == CHR_H) && (head1 == CHR_E) && (head2_eff == CHR_X);
  assign hdr_deg = (head0 == CHR_D) && (head1 == CHR_E) && (head2_eff == CHR_G);
  assign hdr_srv = (head0 == CHR_S) && (head1 == CHR_R) &&
                   ((head2_eff == CHR_V) || (head2_eff == CHR_T));
  assign hdr_ss8 = (head0 == CHR_S) && (head1 == CHR_S) && (head2_eff == CHR_8);
  assign hdr_led = (head0 == CHR_L) && (head1 == CHR_E);

  always_comb begin
    job.kind = KIND_NONE;
    job.ok   = 1'b0;
    if (term_ok) begin
      priority if (hdr_hex) begin
        if (len_fixed) job.kind = KIND_HEX;
      end else if (hdr_deg) begin
        if (len_fixed) job.kind = KIND_DEG;
      end else if (hdr_srv) begin
        if (len_fixed) job.kind = KIND_SRV;
      end else if (hdr_ss8) begin
        if (len_fixed) job.kind = KIND_SS8;
      end else if (hdr_led) begin
        job.kind = KIND_LED;
      end else begin
        job.kind = KIND_NONE;
      end
    end
    job.ok = (job.kind != KIND_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      locked <= 1'b0;
    end else begin
      if (accept) begin
        if (in_ch.end_of_frame) begin
          count <= '0;
        end else if (count < CNT_W'(FRAME_BYTES + 1)) begin
          count <= count + CNT_W'(1);
        end
      end
      if (job_push) begin
        locked <= 1'b1;
      end else if (store_release) begin
        locked <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (count < CNT_W'(FRAME_BYTES)) store[count[ADDR_W-1:0]] <= in_ch.data_byte;
      if (count == CNT_W'(0)) head0 <= in_ch.data_byte;
      if (count == CNT_W'(1)) head1 <= in_ch.data_byte;
      if (count == CNT_W'(2)) head2 <= in_ch.data_byte;
    end
    if (rd_req.en) rd_data <= store[rd_req.addr];
  end

endmodule

`default_nettype wire

[src/rcfd_job_queue.sv]
`default_nettype none

module rcfd_job_queue
  import rcfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t job_in,
  output logic      full,
  input  wire logic pop,
  output job_t      job_out,
  output logic      empty
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= !wr_ptr;
      if (pop && !empty) rd_ptr <= !rd_ptr;
      unique case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= job_in;
  end

endmodule

`default_nettype wire

[src/rcfd_back.sv]
`default_nettype none

module rcfd_back
  import rcfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       queue_empty,
  output logic            queue_pop,
  input  wire job_t       job,
  output rd_req_t         rd_req,
  input  wire logic [7:0] rd_data,
  output logic            store_release,
  rcfd_out_if.source      out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

  typedef enum logic [2:0] {
    ATOI_WS   = 3'b001,
    ATOI_DIG  = 3'b010,
    ATOI_DONE = 3'b100
  } atoi_ph_t;

  function automatic logic [12:0] times10(input logic [7:0] x);
    logic [12:0] w;
    w = {5'd0, x};
    return (w << 3) + (w << 1);
  endfunction

  function automatic logic [3:0] nib_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CHR_ZERO && c <= CHR_NINE) t = c - CHR_ZERO;
    else if (c >= CHR_UA && c <= CHR_UF) t = c - CHR_UA + 8'd10;
    else if (c >= CHR_LA && c <= CHR_LF) t = c - CHR_LA + 8'd10;
    return t[3:0];
  endfunction

  back_state_t       state;
  job_t              cur;
  logic [SCAN_W-1:0] scan_len;
  logic [SCAN_W-1:0] issue_cnt;
  logic              rd_valid;
  logic [3:0]        rd_off;
  atoi_ph_t          atoi_ph;
  logic              atoi_neg;
  logic [13:0]       atoi_val;
  logic [3:0]        nib_hi;
  logic signed [12:0] chan_val [CHANNELS];
  logic [CHANNELS-1:0] chan_pres;
  logic [CH_W-1:0]   ch;

  logic              needs_scan;
  logic              scan_done;
  logic              out_fire;
  logic              is_last;

  // Per-word decode.
  logic              is_digit;
  logic              is_ws;
  logic [3:0]        digit;
  atoi_ph_t          ph_in, ph_out;
  logic              neg_in, neg_out;
  logic [13:0]       val_in, val_out;
  logic [12:0]       srv_res;
  logic [3:0]        nib_lo;
  logic              wr_en;
  logic [3:0]        wr_slot;
  logic signed [12:0] wr_val;

  assign needs_scan = job.ok && (job.kind == KIND_HEX || job.kind == KIND_DEG ||
                                 job.kind == KIND_SRV || job.kind == KIND_SS8);
  assign queue_pop  = (state == ST_IDLE) && !queue_empty;
  assign scan_done  = (state == ST_SCAN) && rd_valid &&
                      (SCAN_W'(rd_off) == scan_len - SCAN_W'(1));
  assign store_release = (queue_pop && !needs_scan) || scan_done;

  assign rd_req.en   = (state == ST_SCAN) && (issue_cnt < scan_len);
  assign rd_req.addr = ADDR_W'(issue_cnt) + ADDR_W'(HDR_BYTES);

  always_comb begin
    is_digit = (rd_data >= CHR_ZERO) && (rd_data <= CHR_NINE);
    is_ws    = (rd_data == CHR_SPACE) || ((rd_data >= CHR_TAB) && (rd_data <= CHR_CR));
    digit    = 4'(rd_data - CHR_ZERO);

    // Each four-word field starts the integer parse afresh.
    if (rd_off[1:0] == 2'd0) begin
      ph_in  = ATOI_WS;
      neg_in = 1'b0;
      val_in = '0;
    end else begin
      ph_in  = atoi_ph;
      neg_in = atoi_neg;
      val_in = atoi_val;
    end
    ph_out  = ph_in;
    neg_out = neg_in;
    val_out = val_in;
    unique case (ph_in)
      ATOI_WS: begin
        if (is_ws) begin
          ph_out = ATOI_WS;
        end else if (rd_data == CHR_PLUS || rd_data == CHR_MINUS) begin
          neg_out = (rd_data == CHR_MINUS);
          ph_out  = ATOI_DIG;
        end else if (is_digit) begin
          val_out = {10'd0, digit};
          ph_out  = ATOI_DIG;
        end else begin
          ph_out = ATOI_DONE;
        end
      end
      ATOI_DIG: begin
        if (is_digit) begin
          val_out = (val_in << 3) + (val_in << 1) + {10'd0, digit};
        end else begin
          ph_out = ATOI_DONE;
        end
      end
      default: begin
        ph_out = ATOI_DONE;
      end
    endcase
    // A negative field always clamps to zero.
    if (neg_out) srv_res = 13'd0;
    else if (val_out > SRV_MAX) srv_res = SRV_MAX[12:0];
    else srv_res = val_out[12:0];

    nib_lo  = nib_of(rd_data);
    wr_en   = 1'b0;
    wr_slot = rd_off;
    wr_val  = VAL_DEFAULT;
    unique case (cur.kind)
      KIND_HEX: begin
        wr_en  = 1'b1;
        wr_val = signed'(times10(rd_data));
      end
      KIND_DEG: begin
        wr_en  = 1'b1;
        wr_val = signed'({{5{rd_data[7]}}, rd_data}) - DEG_OFFSET;
      end
      KIND_SRV: begin
        wr_en   = (rd_off[1:0] == 2'd3);
        wr_slot = rd_off >> 2;
        wr_val  = signed'(srv_res);
      end
      KIND_SS8: begin
        wr_en   = rd_off[0];
        wr_slot = rd_off >> 1;
        wr_val  = signed'(times10({nib_hi, nib_lo}));
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign is_last  = (ch == CH_W'(CHANNELS - 1));
  assign out_fire = out_ch.valid && out_ch.ready;

  assign out_ch.valid           = (state == ST_EMIT);
  assign out_ch.frame_kind      = cur.kind;
  assign out_ch.frame_ok        = cur.ok;
  assign out_ch.channel_index   = 4'(ch);
  assign out_ch.channel_value   = chan_pres[ch] ? chan_val[ch] : VAL_DEFAULT;
  assign out_ch.channel_present = chan_pres[ch];
  assign out_ch.last_channel    = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      issue_cnt <= '0;
      ch        <= '0;
    end else begin
      rd_valid <= rd_req.en;
      unique case (state)
        ST_IDLE: begin
          if (queue_pop) begin
            issue_cnt <= '0;
            ch        <= '0;
            state     <= needs_scan ? ST_SCAN : ST_EMIT;
          end
        end
        ST_SCAN: begin
          if (rd_req.en) issue_cnt <= issue_cnt + SCAN_W'(1);
          if (scan_done) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_fire) begin
            if (is_last) state <= ST_IDLE;
            else ch <= ch + CH_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (queue_pop) begin
      cur       <= job;
      chan_pres <= '0;
      scan_len  <= (job.kind == KIND_HEX || job.kind == KIND_DEG) ?
                   SCAN_W'(CHANNELS) : SCAN_W'(SCAN_MAX);
    end else if (state == ST_SCAN && rd_valid && wr_en) begin
      chan_pres[wr_slot[CH_W-1:0]] <= 1'b1;
    end
    if (state == ST_SCAN && rd_valid) begin
      atoi_ph  <= ph_out;
      atoi_neg <= neg_out;
      atoi_val <= val_out;
      if (!rd_off[0]) nib_hi <= nib_lo;
      if (wr_en) chan_val[wr_slot[CH_W-1:0]] <= wr_val;
    end
    if (rd_req.en) rd_off <= issue_cnt[3:0];
  end

  // Store data only comes back while a scan is running.
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_SCAN))
    else $error("store read data outside of a scan");

  // The result after the final channel closes the frame.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_fire && is_last) |=> (state == ST_IDLE))
    else $error("emit did not end after the final channel");

  // The store is handed back once per frame, never twice in a row.
  a_release_pulse: assert property (@(posedge clk) disable iff (rst)
    store_release |=> !store_release)
    else $error("store released on consecutive cycles");

  // The channel counter stays within the channel range.
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (ch <= CH_W'(CHANNELS - 1)))
    else $error("channel counter out of range");

endmodule

`default_nettype wire

[src/rc_control_frame_decoder.sv]
`default_nettype none

// Flow: the final word pushes a job into the queue, which the back pops when idle; HEX, DEG,
// SRV and SS8 frames then read 16 store words through the registered read port before the
// first result, and frames that need no scan go straight to results. Throughput: 16 results
// follow at one per cycle while the receiver is ready. After a final word the input stalls
// until the store is released: after the scan, or on the pop of a job that needs none.
// Reset (synchronous, rst high) clears the byte count, store lock, job queue and back state;
// the frame store and header registers keep their contents and are not cleared.

module rc_control_frame_decoder
  import rcfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  rcfd_in_if.sink    in_ch,
  rcfd_out_if.source out_ch
);

  // The front counts and stores the frame words and classifies the frame on its
  // final word, checking the trailing hash, the header and the fixed length.
  // Classified frames wait in a two-entry job queue. The back takes one job at a
  // time, walks the payload words of the store through its registered read port
  // while decoding each channel when the kind carries values, then hands the store back to
  // the front and emits one result word per channel. Because decoded values sit in the back's
  // own registers, the front can take the next frame while results drain.

  job_t    job_in;
  job_t    job_out;
  logic    job_push;
  logic    job_pop;
  logic    queue_full;
  logic    queue_empty;
  rd_req_t rd_req;
  logic [7:0] rd_data;
  logic    store_release;

  rcfd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .queue_full    (queue_full),
    .job_push      (job_push),
    .job           (job_in),
    .rd_req        (rd_req),
    .rd_data       (rd_data),
    .store_release (store_release)
  );

  rcfd_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .full    (queue_full),
    .pop     (job_pop),
    .job_out (job_out),
    .empty   (queue_empty)
  );

  rcfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .queue_pop     (job_pop),
    .job           (job_out),
    .rd_req        (rd_req),
    .rd_data       (rd_data),
    .store_release (store_release),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

[tb/sv/rc_control_frame_decoder_tb.sv]
`timescale 1ns / 100ps

module rc_control_frame_decoder_tb;
  import rcfd_pkg::*;

  // Payload bytes between the header and the terminator of a fixed-length frame.
  localparam int BODY_BYTES   = FRAME_BYTES - HDR_BYTES - 1;
  // Bytes in the random part of the run.
  localparam int RANDOM_BYTES = 144;
  // Watchdog limit.
  localparam int CYCLE_LIMIT  = 400000;
  // Cycles to wait after the last channel word before the verdict.
  localparam int SETTLE_CYCLES = 40;

  // One channel word as the block reports it.
  typedef struct {
    kind_t              kind;
    logic               ok;
    logic [3:0]         chan;
    logic signed [12:0] value;
    logic               present;
    logic               last;
  } chan_result_t;

  // The scoreboard keeps its own image of the frame and the length counter. It turns
  // every accepted byte into the channel words it should cause, and it checks each
  // channel word that leaves the block against the oldest of them.
  class channel_scoreboard;
    logic [7:0]   frame_image [FRAME_BYTES];
    int unsigned  frame_len;
    chan_result_t expected_q [$];
    int unsigned  mismatches;

    function new();
      frame_len  = 0;
      mismatches = 0;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    // A character that is not a hex digit counts as zero.
    function int hex_digit(logic [7:0] c);
      if (c >= CHR_ZERO && c <= CHR_NINE) return int'(c - CHR_ZERO);
      if (c >= CHR_UA && c <= CHR_UF) return 10 + int'(c - CHR_UA);
      if (c >= CHR_LA && c <= CHR_LF) return 10 + int'(c - CHR_LA);
      return 0;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
    endfunction

    // Reads one four-character servo field the way atoi does: leading white space,
    // an optional sign, then digits up to the first non-digit. The result is clamped.
    function int servo_field(int at);
      int p;
      bit neg;
      int v;
      p   = 0;
      neg = 1'b0;
      v   = 0;
      while (p < 4 && is_space(frame_image[at + p])) p++;
      if (p < 4 && (frame_image[at + p] == CHR_PLUS || frame_image[at + p] == CHR_MINUS)) begin
        neg = frame_image[at + p] == CHR_MINUS;
        p++;
      end
      while (p < 4 && frame_image[at + p] >= CHR_ZERO && frame_image[at + p] <= CHR_NINE) begin
        v = v * 10 + int'(frame_image[at + p] - CHR_ZERO);
        p++;
      end
      if (neg) v = -v;
      if (v < 0) v = 0;
      if (v > int'(SRV_MAX)) v = int'(SRV_MAX);
      return v;
    endfunction

    function bit header_is(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      return frame_image[0] == a && frame_image[1] == b && frame_image[2] == c;
    endfunction

    // Called for every byte the block accepts.
    function void note_byte(logic [7:0] b, logic eof);
      int           values [CHANNELS];
      bit           present [CHANNELS];
      kind_t        kind;
      bit           ok;
      int unsigned  len;
      bit           fixed;
      chan_result_t r;
      if (frame_len < FRAME_BYTES) frame_image[frame_len] = b;
      if (frame_len < FRAME_BYTES + 1) frame_len++;
      if (!eof) return;

      len       = frame_len;
      frame_len = 0;
      kind      = KIND_NONE;
      ok        = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        values[i]  = int'(VAL_DEFAULT);
        present[i] = 1'b0;
      end

      // Only a frame that ends in the terminator and holds a header is looked at.
      // Every header except LED needs the exact frame length.
      if (b == CHR_HASH && len >= HDR_BYTES) begin
        fixed = len == FRAME_BYTES;
        if (header_is(CHR_H, CHR_E, CHR_X)) begin
          if (fixed) begin
            kind = KIND_HEX;
            ok   = 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
              values[i]  = int'(frame_image[HDR_BYTES + i]) * 10;
              present[i] = 1'b1;
            end
          end
        end else if (header_is(CHR_D, CHR_E, CHR_G)) begin
          if (fixed) begin
            kind = KIND_DEG;
            ok   = 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
              values[i]  = int'($signed(frame_image[HDR_BYTES + i])) - int'(DEG_OFFSET);
              present[i] = 1'b1;
            end
          end
        end else if (header_is(CHR_S, CHR_R, CHR_V) || header_is(CHR_S, CHR_R, CHR_T)) begin
          if (fixed) begin
            kind = KIND_SRV;
            ok   = 1'b1;
            for (int i = 0; i < 4; i++) begin
              values[i]  = servo_field(HDR_BYTES + i * 4);
              present[i] = 1'b1;
            end
          end
        end else if (header_is(CHR_S, CHR_S, CHR_8)) begin
          if (fixed) begin
            kind = KIND_SS8;
            ok   = 1'b1;
            for (int i = 0; i < 8; i++) begin
              values[i]  = (hex_digit(frame_image[HDR_BYTES + 2 * i]) * 16 +
                            hex_digit(frame_image[HDR_BYTES + 2 * i + 1])) * 10;
              present[i] = 1'b1;
            end
          end
        end else if (frame_image[0] == CHR_L && frame_image[1] == CHR_E) begin
          kind = KIND_LED;
          ok   = 1'b1;
        end
      end

      for (int i = 0; i < CHANNELS; i++) begin
        r.kind    = kind;
        r.ok      = ok;
        r.chan    = 4'(i);
        r.value   = 13'(values[i]);
        r.present = present[i];
        r.last    = i == CHANNELS - 1;
        expected_q.push_back(r);
      end
    endfunction

    // Called for every channel word the block hands over.
    function void check_result(chan_result_t got);
      chan_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("Unexpected channel word: ch %0d value %0d", got.chan, got.value));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.ok !== want.ok || got.chan !== want.chan ||
          got.value !== want.value || got.present !== want.present ||
          got.last !== want.last)
        flag($sformatf({"Channel word mismatch: expected kind %0d ok %0b ch %0d value %0d ",
                        "present %0b last %0b, got kind %0d ok %0b ch %0d value %0d ",
                        "present %0b last %0b"},
                       want.kind, want.ok, want.chan, want.value, want.present, want.last,
                       got.kind, got.ok, got.chan, got.value, got.present, got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rcfd_in_if  in_ch ();
  rcfd_out_if out_ch ();

  rc_control_frame_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  channel_scoreboard sb = new();

  // Sender state. The sender works in bursts; in steady stretches it never idles.
  logic [7:0]  frame_bytes [$];
  int          burst_left = 0;
  bit          steady = 1'b0;
  int unsigned bytes_sent = 0;

  // Receiver state. The ready pattern has eight entries and is redrawn each time the tick
  // counter wraps; about a quarter of the windows never stall.
  logic         rx_ready = 1'b0;
  logic [5:0]   stall_tick = '0;
  logic [7:0]   stall_pattern = 8'hFF;
  chan_result_t rx_word;
  int           cycle_count = 0;

  assign out_ch.ready = rx_ready;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      rx_word.kind    = kind_t'(out_ch.frame_kind);
      rx_word.ok      = out_ch.frame_ok;
      rx_word.chan    = out_ch.channel_index;
      rx_word.value   = out_ch.channel_value;
      rx_word.present = out_ch.channel_present;
      rx_word.last    = out_ch.last_channel;
      sb.check_result(rx_word);
    end
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    rx_ready <= stall_pattern[stall_tick[2:0]];
  end

  // Watchdog: a hung handshake or a missing channel word ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drives one word and waits for it to be taken. A fresh burst may start with an idle
  // gap. Valid stays high from one word to the next inside a burst, so it is never
  // lowered and raised in the same time step.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    if (burst_left == 0) begin
      gap        = steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.end_of_frame <= eof;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_byte(b, eof);
    bytes_sent++;
  endtask

  // Sends the assembled frame with the end flag on its last word.
  task automatic send_frame();
    for (int k = 0; k < frame_bytes.size(); k++)
      send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  // Holds the sender off until every expected channel word has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic put(input string s);
    for (int k = 0; k < s.len(); k++) frame_bytes.push_back(s[k]);
  endtask

  task automatic put_byte(input logic [7:0] b);
    frame_bytes.push_back(b);
  endtask

  // Body byte biased toward the values where scaling and the sign of DEG change.
  function automatic logic [7:0] edge_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    if (r < 40) return 8'h7F;
    if (r < 50) return 8'h80;
    return 8'($urandom);
  endfunction

  // Character for a servo field: mostly digits, with white space, signs and junk.
  function automatic logic [7:0] servo_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return CHR_ZERO + 8'($urandom_range(0, 9));
    if (r < 65) return CHR_SPACE;
    if (r < 72) return CHR_TAB + 8'($urandom_range(0, 4));
    if (r < 80) return CHR_PLUS;
    if (r < 88) return CHR_MINUS;
    return 8'($urandom);
  endfunction

  // Character for an SS8 pair: digits, both letter cases, now and then a non-hex byte.
  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CHR_ZERO + 8'($urandom_range(0, 9));
    if (r < 65) return CHR_UA + 8'($urandom_range(0, 5));
    if (r < 90) return CHR_LA + 8'($urandom_range(0, 5));
    return 8'($urandom);
  endfunction

  function automatic string header_name(input int k);
    case (k)
      0:       return "HEX";
      1:       return "DEG";
      2:       return $urandom_range(0, 1) ? "SRV" : "SRT";
      default: return "SS8";
    endcase
  endfunction

  // Most random frames are well formed with random content; the rest have a wrong
  // length, a wrong terminator, a damaged header, or are plain noise.
  task automatic build_random_frame();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      put("HEX");
      repeat (BODY_BYTES) put_byte(edge_byte());
      put_byte(CHR_HASH);
    end else if (pick < 28) begin
      put("DEG");
      repeat (BODY_BYTES) put_byte(edge_byte());
      put_byte(CHR_HASH);
    end else if (pick < 42) begin
      put(header_name(2));
      repeat (BODY_BYTES / 4) begin
        // Some fields are plain four-digit numbers, many of them above the clamp.
        if ($urandom_range(0, 2) == 0)
          repeat (4) put_byte(CHR_ZERO + 8'($urandom_range(0, 9)));
        else
          repeat (4) put_byte(servo_char());
      end
      put_byte(CHR_HASH);
    end else if (pick < 56) begin
      put("SS8");
      repeat (BODY_BYTES) put_byte(hex_char());
      put_byte(CHR_HASH);
    end else if (pick < 66) begin
      // LED frames pass at any length, including past the end of the store.
      put("LE");
      len = $urandom_range(3, 28);
      repeat (len - 3) put_byte(8'($urandom));
      put_byte(CHR_HASH);
    end else if (pick < 76) begin
      len = $urandom_range(4, 26);
      if (len == FRAME_BYTES) len++;
      put(header_name($urandom_range(0, 3)));
      repeat (len - 4) put_byte(8'($urandom));
      put_byte(CHR_HASH);
    end else if (pick < 84) begin
      put(header_name($urandom_range(0, 3)));
      repeat (BODY_BYTES) put_byte(8'($urandom));
      put_byte(8'($urandom));
    end else if (pick < 92) begin
      len = $urandom_range(1, 24);
      repeat (len - 1) put_byte(8'($urandom));
      put_byte($urandom_range(0, 1) ? CHR_HASH : 8'($urandom));
    end else begin
      put(header_name($urandom_range(0, 3)));
      frame_bytes[$urandom_range(0, HDR_BYTES - 1)] = 8'($urandom);
      repeat (BODY_BYTES) put_byte(8'($urandom));
      put_byte(CHR_HASH);
    end
  endtask

  initial begin
    logic [7:0] deg_probe [4];
    int         frames_done;
    deg_probe = '{8'h00, 8'h7F, 8'h80, 8'hFF};

    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.end_of_frame <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed frames. HEX with the smallest and largest byte values.
    put("HEX");
    for (int k = 0; k < BODY_BYTES; k++) put_byte((k % 2) ? 8'hFF : 8'h00);
    put_byte(CHR_HASH);
    send_frame();
    // DEG across the sign boundary of the byte.
    put("DEG");
    for (int k = 0; k < BODY_BYTES; k++) put_byte(deg_probe[k % 4]);
    put_byte(CHR_HASH);
    send_frame();
    // Servo fields at the clamp, negative, and with white space before a sign.
    put("SRV3000-123 +453001#");
    send_frame();
    // The SRT alias; tab and carriage return; a sign after a sign; digits past the clamp.
    put("SRT\011\015 7+-12   -9999#");
    send_frame();
    // Line feed, vertical tab and form feed as white space; a byte that stops the scan;
    // zeros with and without a sign.
    put("SRV\012\013\0145\0101230000-000#");
    send_frame();
    // A lone sign, a sign followed by space, trailing space, a leading zero.
    put("SRV  + -  5 12 0999#");
    send_frame();
    // SS8 with both letter cases and characters that are not hex.
    put("SS800FFa5fGzz9A0b1C#");
    send_frame();
    // Shortest LED frame, and an LED frame far longer than the store.
    put("LE#");
    send_frame();
    put("LED");
    repeat (24) put_byte(8'($urandom));
    put_byte(CHR_HASH);
    send_frame();
    // Fixed-length headers one byte long, far too long, and one byte short.
    put("HEX");
    repeat (BODY_BYTES + 1) put_byte(8'($urandom));
    put_byte(CHR_HASH);
    send_frame();
    put("SS8");
    repeat (BODY_BYTES + 10) put_byte(hex_char());
    put_byte(CHR_HASH);
    send_frame();
    put("HEX");
    repeat (BODY_BYTES - 1) put_byte(8'($urandom));
    put_byte(CHR_HASH);
    send_frame();
    put("DEG#");
    send_frame();
    // Right length but a wrong terminator.
    put("HEX");
    repeat (BODY_BYTES) put_byte(8'($urandom));
    put("$");
    send_frame();
    // Frames too short to hold a header, with and without the terminator.
    put("#");
    send_frame();
    put("L#");
    send_frame();
    put("E");
    send_frame();
    // Unknown headers and near misses of real ones.
    put("ABC");
    repeat (BODY_BYTES) put_byte(8'($urandom));
    put_byte(CHR_HASH);
    send_frame();
    put("HEY");
    repeat (BODY_BYTES) put_byte(8'($urandom));
    put_byte(CHR_HASH);
    send_frame();
    put("SR8");
    repeat (BODY_BYTES) put_byte(hex_char());
    put_byte(CHR_HASH);
    send_frame();
    put("LEX#");
    send_frame();
    put("LX#");
    send_frame();

    // Let the block run dry once before the random part.
    wait_drained();

    bytes_sent  = 0;
    frames_done = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      steady = $urandom_range(0, 4) == 0;
      build_random_frame();
      send_frame();
      frames_done++;
      if (frames_done == 4) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
